>>> hdl/grid_ray_horizontal_hit_top_defines.svh
// assertion macros for the horizontal grid-line ray caster
// used by the port checker; needs i_clk and i_rst_n in scope
`ifndef GRID_RAY_HORIZONTAL_HIT_TOP_DEFINES_SVH
`define GRID_RAY_HORIZONTAL_HIT_TOP_DEFINES_SVH

// same-cycle implication
`define GRHH_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define GRHH_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// implication after a fixed number of cycles
`define GRHH_ASSERT_DLY(lbl, ante, dly, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> ##dly (cons)) \
        else $error(msg);

`endif

>>> hdl/grhh_pkg.sv
// shared constants, types and the negated-cotangent table of the ray caster
// no dependencies; the table is built at elaboration by a constant function
package grhh_pkg;

    // sizes of the map, the walk and the angle
    localparam int MAX_COLS   = 64;
    localparam int MAX_ROWS   = 64;
    localparam int MAX_STEPS  = 18;
    localparam int ANGLE_BITS = 12;

    // field and register widths
    localparam int CFG_W     = 7;
    localparam int CFG_IDX_W = 1;
    localparam int CELL_W    = 6;
    localparam int POS_W     = 18;
    localparam int OUT_W     = 24;

    // fixed point layout: Q.8 coordinates, one cell is 4096 lsb, cotangent signed Q7.16
    localparam int CELL_SHIFT = 12;
    localparam int CELL_Q8    = 1 << CELL_SHIFT;
    localparam int NC_W       = 24;
    localparam int NC_FRAC    = 16;
    localparam int XO_SHIFT   = NC_FRAC - CELL_SHIFT;
    localparam int XO_W       = NC_W - XO_SHIFT + 1;
    localparam int DY_W       = CELL_SHIFT + 2;
    localparam int PROD_W     = DY_W + NC_W;
    localparam int RX_W       = 27;
    localparam int RY_W       = 21;
    localparam int MX_W       = RX_W - CELL_SHIFT;
    localparam int MY_W       = RY_W - CELL_SHIFT;
    localparam int BND_W      = 9;

    // wall map geometry
    localparam int COL_AW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int ROW_AW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int MAP_DEPTH = MAX_COLS * MAX_ROWS;
    localparam int MAP_AW    = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;
    localparam int STEP_W    = $clog2(MAX_STEPS + 1);

    // cotangent table covers half a turn
    localparam int NC_AW    = ANGLE_BITS - 1;
    localparam int NC_DEPTH = 1 << NC_AW;

    // item kinds carried on tuser
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_CAST  = 1'b1;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAP_COLS = 1'b0,
        CFG_MAP_ROWS = 1'b1
    } t_cfg_idx;

    // commands from controller to datapath
    typedef struct packed {
        logic acc_wr;
        logic acc_cast;
        logic mul;
        logic init;
        logic step;
        logic back;
        logic load_out;
    } t_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic axis;
        logic wall_hit;
        logic at_limit;
        logic out_bounds;
    } t_sts;

    typedef logic signed [NC_W-1:0] t_nc_rom [NC_DEPTH];

    localparam longint unsigned PI_Q30  = 64'd3373259426;
    localparam longint unsigned ONE_Q30 = 64'd1073741824;
    localparam longint unsigned NC_POS_LIM = 64'd8388607;
    localparam longint unsigned NC_NEG_LIM = 64'd8388608;

    // restoring shift-subtract division for table building
    function automatic longint unsigned udiv64(input longint unsigned n,
                                               input longint unsigned d);
        logic [64:0]     rem;
        longint unsigned quo;
        int              i;
        rem = '0;
        quo = '0;
        for (i = 63; i >= 0; i--) begin
            rem = {rem[63:0], n[i]};
            if (rem >= {1'b0, d}) begin
                rem    = rem - {1'b0, d};
                quo[i] = 1'b1;
            end
        end
        return quo;
    endfunction

    // -cot over half a turn from Q30 Taylor sine and cosine, saturated signed Q7.16
    function automatic t_nc_rom build_nc_rom();
        t_nc_rom         tab;
        longint unsigned x, x2, ts, tc, num, den, mag;
        longint          s, c, sn, cs;
        int unsigned     r, q, k;
        int              i;
        for (i = 0; i < NC_DEPTH; i++) begin
            q  = (i >> (ANGLE_BITS - 2)) & 1;
            r  = i & ((1 << (ANGLE_BITS - 2)) - 1);
            x  = (longint'(r) * PI_Q30) >> (ANGLE_BITS - 1);
            x2 = (x * x) >> 30;
            ts = x;
            tc = ONE_Q30;
            s  = longint'(x);
            c  = longint'(ONE_Q30);
            for (k = 1; k <= 7; k++) begin
                ts = udiv64((ts * x2) >> 30, longint'((2 * k) * (2 * k + 1)));
                tc = udiv64((tc * x2) >> 30, longint'((2 * k - 1) * (2 * k)));
                if ((k & 1) != 0) begin
                    s = s - longint'(ts);
                    c = c - longint'(tc);
                end else begin
                    s = s + longint'(ts);
                    c = c + longint'(tc);
                end
            end
            if (q == 0) begin
                sn = s;
                cs = c;
            end else begin
                sn = c;
                cs = -s;
            end
            if (sn == 0) begin
                tab[i] = '0;
            end else begin
                num = longint'((cs < 0) ? -cs : cs) << 16;
                den = longint'((sn < 0) ? -sn : sn);
                mag = udiv64(num, den);
                if ((cs < 0) == (sn < 0)) begin
                    if (mag > NC_NEG_LIM) tab[i] = NC_W'(-longint'(NC_NEG_LIM));
                    else tab[i] = NC_W'(-longint'(mag));
                end else begin
                    if (mag > NC_POS_LIM) tab[i] = NC_W'(NC_POS_LIM);
                    else tab[i] = NC_W'(mag);
                end
            end
        end
        return tab;
    endfunction

    localparam t_nc_rom NC_ROM = build_nc_rom();

endpackage

>>> hdl/grhh_ctrl.sv
// controller of the ray caster: sequences setup, map walk and result hand-off
// depends on grhh_pkg for the command and status structs
module grhh_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_in_kind,
    output logic           o_in_ready,
    input  logic           i_out_ready,
    output logic           o_out_valid,
    input  grhh_pkg::t_sts i_sts,
    output grhh_pkg::t_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_INIT,
        S_WALK,
        S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    // next state and datapath commands
    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_in_kind == grhh_pkg::CMD_CAST) begin
                        o_cmd.acc_cast = 1'b1;
                        n_state        = S_MUL;
                    end else begin
                        o_cmd.acc_wr = 1'b1;
                    end
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_INIT;
            end
            S_INIT: begin
                o_cmd.init = 1'b1;
                n_state    = i_sts.axis ? S_DONE : S_WALK;
            end
            S_WALK: begin
                // wall behind the previous line wins over the current point
                if (i_sts.wall_hit) begin
                    o_cmd.back = 1'b1;
                    n_state    = S_DONE;
                end else if (i_sts.at_limit || i_sts.out_bounds) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.step = 1'b1;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state and output word valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

>>> hdl/grhh_dpath.sv
// datapath of the ray caster: config registers, wall map, cotangent lookup,
// first-line setup, row stepping and the output word; depends on grhh_pkg
module grhh_dpath (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  grhh_pkg::t_cmd                          i_cmd,
    output grhh_pkg::t_sts                          o_sts,
    input  logic                                    i_cfg_we,
    input  logic [grhh_pkg::CFG_IDX_W-1:0]          i_cfg_idx,
    input  logic [grhh_pkg::CFG_W-1:0]              i_cfg_data,
    input  logic [grhh_pkg::CELL_W-1:0]             i_cell_col,
    input  logic [grhh_pkg::CELL_W-1:0]             i_cell_row,
    input  logic                                    i_cell_wall,
    input  logic [grhh_pkg::POS_W-1:0]              i_player_x,
    input  logic [grhh_pkg::POS_W-1:0]              i_player_y,
    input  logic [grhh_pkg::ANGLE_BITS-1:0]         i_view_angle,
    input  logic [grhh_pkg::ANGLE_BITS-1:0]         i_ray_offset,
    output logic [grhh_pkg::OUT_W-1:0]              o_hit_x,
    output logic [grhh_pkg::OUT_W-1:0]              o_hit_y
);

    localparam logic [grhh_pkg::ANGLE_BITS-1:0] ANG_HALF =
        grhh_pkg::ANGLE_BITS'(1 << (grhh_pkg::ANGLE_BITS - 1));
    localparam logic signed [grhh_pkg::RX_W-1:0] SAT_HI =
        grhh_pkg::RX_W'((1 << (grhh_pkg::OUT_W - 1)) - 1);
    localparam logic signed [grhh_pkg::RX_W-1:0] SAT_LO =
        -grhh_pkg::RX_W'(1 << (grhh_pkg::OUT_W - 1));

    // configuration
    logic [grhh_pkg::CFG_W-1:0] r_map_cols;
    logic [grhh_pkg::CFG_W-1:0] r_map_rows;

    // cast setup
    logic [grhh_pkg::POS_W-1:0]         r_px;
    logic                               r_axis;
    logic                               r_down;
    logic signed [grhh_pkg::NC_W-1:0]   r_nc;
    logic signed [grhh_pkg::DY_W-1:0]   r_dy;
    logic signed [grhh_pkg::PROD_W-1:0] r_prod;
    logic signed [grhh_pkg::XO_W-1:0]   r_xo;

    // walk
    logic signed [grhh_pkg::RX_W-1:0]   r_rx;
    logic signed [grhh_pkg::RY_W-1:0]   r_ry;
    logic signed [grhh_pkg::RX_W-1:0]   r_prev_x;
    logic signed [grhh_pkg::RY_W-1:0]   r_prev_y;
    logic [grhh_pkg::STEP_W-1:0]        r_cnt;
    logic                               r_pend;

    // wall map
    logic                               r_wall_map [grhh_pkg::MAP_DEPTH];
    logic                               r_wall_q;

    logic [grhh_pkg::ANGLE_BITS-1:0]    ang;
    logic                               ang_axis;
    logic                               ang_down;
    logic [grhh_pkg::POS_W-1:0]         base_y;
    logic [grhh_pkg::CELL_SHIFT-1:0]    frac_y;
    logic signed [grhh_pkg::NC_W:0]     nc_neg;
    logic [grhh_pkg::BND_W-1:0]         lim_cols;
    logic [grhh_pkg::BND_W-1:0]         lim_rows;
    logic [grhh_pkg::MX_W-1:0]          mx;
    logic [grhh_pkg::MY_W-1:0]          my;
    logic [grhh_pkg::MAP_AW-1:0]        rd_addr;
    logic [grhh_pkg::MAP_AW-1:0]        wr_addr;
    logic                               wr_en;
    logic signed [grhh_pkg::RX_W-1:0]   ry_ext;

    function automatic logic [grhh_pkg::OUT_W-1:0] sat_out(
        input logic signed [grhh_pkg::RX_W-1:0] v
    );
        logic [grhh_pkg::OUT_W-1:0] res;
        if (v > SAT_HI) res = grhh_pkg::OUT_W'(SAT_HI);
        else if (v < SAT_LO) res = grhh_pkg::OUT_W'(SAT_LO);
        else res = v[grhh_pkg::OUT_W-1:0];
        return res;
    endfunction

    // ray angle and direction
    assign ang      = i_view_angle + i_ray_offset;
    assign ang_axis = (ang == '0) || (ang == ANG_HALF);
    assign ang_down = (ang > ANG_HALF);
    assign base_y   = {i_player_y[grhh_pkg::POS_W-1:grhh_pkg::CELL_SHIFT],
                       grhh_pkg::CELL_SHIFT'(0)};
    assign frac_y   = i_player_y[grhh_pkg::CELL_SHIFT-1:0];
    assign nc_neg   = -((grhh_pkg::NC_W + 1)'(r_nc));

    // effective map bounds
    assign lim_cols = (grhh_pkg::BND_W'(r_map_cols) < grhh_pkg::BND_W'(grhh_pkg::MAX_COLS))
                    ? grhh_pkg::BND_W'(r_map_cols) : grhh_pkg::BND_W'(grhh_pkg::MAX_COLS);
    assign lim_rows = (grhh_pkg::BND_W'(r_map_rows) < grhh_pkg::BND_W'(grhh_pkg::MAX_ROWS))
                    ? grhh_pkg::BND_W'(r_map_rows) : grhh_pkg::BND_W'(grhh_pkg::MAX_ROWS);

    // cell of the current point
    assign mx = r_rx[grhh_pkg::RX_W-1:grhh_pkg::CELL_SHIFT];
    assign my = r_ry[grhh_pkg::RY_W-1:grhh_pkg::CELL_SHIFT];

    assign rd_addr = grhh_pkg::MAP_AW'(my[grhh_pkg::ROW_AW-1:0])
                   * grhh_pkg::MAP_AW'(grhh_pkg::MAX_COLS)
                   + grhh_pkg::MAP_AW'(mx[grhh_pkg::COL_AW-1:0]);
    assign wr_addr = grhh_pkg::MAP_AW'(i_cell_row[grhh_pkg::ROW_AW-1:0])
                   * grhh_pkg::MAP_AW'(grhh_pkg::MAX_COLS)
                   + grhh_pkg::MAP_AW'(i_cell_col[grhh_pkg::COL_AW-1:0]);
    assign wr_en   = i_cmd.acc_wr
                   && (grhh_pkg::BND_W'(i_cell_col) < grhh_pkg::BND_W'(grhh_pkg::MAX_COLS))
                   && (grhh_pkg::BND_W'(i_cell_row) < grhh_pkg::BND_W'(grhh_pkg::MAX_ROWS));

    // status to the controller
    assign o_sts.axis       = r_axis;
    assign o_sts.wall_hit   = r_pend && r_wall_q;
    assign o_sts.at_limit   = (r_cnt == grhh_pkg::STEP_W'(grhh_pkg::MAX_STEPS));
    assign o_sts.out_bounds = mx[grhh_pkg::MX_W-1] || my[grhh_pkg::MY_W-1]
                           || (mx >= grhh_pkg::MX_W'(lim_cols))
                           || (my >= grhh_pkg::MY_W'(lim_rows));

    assign ry_ext = grhh_pkg::RX_W'(r_ry);

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_cols <= grhh_pkg::CFG_W'(64);
            r_map_rows <= grhh_pkg::CFG_W'(64);
        end else if (i_cfg_we) begin
            unique case (grhh_pkg::t_cfg_idx'(i_cfg_idx))
                grhh_pkg::CFG_MAP_COLS: r_map_cols <= i_cfg_data;
                grhh_pkg::CFG_MAP_ROWS: r_map_rows <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // wall map: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_wall_map[wr_addr] <= i_cell_wall;
        end
        r_wall_q <= r_wall_map[rd_addr];
    end

    // walk control bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 1'b0;
            r_cnt  <= '0;
        end else if (i_cmd.init || i_cmd.back) begin
            r_pend <= 1'b0;
            r_cnt  <= '0;
        end else if (i_cmd.step) begin
            r_pend <= 1'b1;
            r_cnt  <= r_cnt + 1'b1;
        end
    end

    // setup, stepping and output word
    always_ff @(posedge i_clk) begin
        // latch the cast and look up -cot
        if (i_cmd.acc_cast) begin
            r_px   <= i_player_x;
            r_axis <= ang_axis;
            r_down <= ang_down;
            r_nc   <= grhh_pkg::NC_ROM[ang[grhh_pkg::NC_AW-1:0]];
            if (ang_axis) begin
                r_ry <= grhh_pkg::RY_W'(i_player_y);
            end else if (ang_down) begin
                r_ry <= grhh_pkg::RY_W'(base_y) - grhh_pkg::RY_W'(1);
            end else begin
                r_ry <= grhh_pkg::RY_W'(base_y) + grhh_pkg::RY_W'(grhh_pkg::CELL_Q8);
            end
            if (ang_down) begin
                r_dy <= grhh_pkg::DY_W'(frac_y) + grhh_pkg::DY_W'(1);
            end else begin
                r_dy <= grhh_pkg::DY_W'(frac_y) - grhh_pkg::DY_W'(grhh_pkg::CELL_Q8);
            end
        end
        // offset to the first line and per-row x step
        if (i_cmd.mul) begin
            r_prod <= grhh_pkg::PROD_W'(r_dy) * grhh_pkg::PROD_W'(r_nc);
            if (r_down) begin
                r_xo <= grhh_pkg::XO_W'(r_nc >>> grhh_pkg::XO_SHIFT);
            end else begin
                r_xo <= grhh_pkg::XO_W'(nc_neg >>> grhh_pkg::XO_SHIFT);
            end
        end
        // first crossing point
        if (i_cmd.init) begin
            if (r_axis) begin
                r_rx <= grhh_pkg::RX_W'(r_px);
            end else begin
                r_rx <= grhh_pkg::RX_W'(r_px)
                      + grhh_pkg::RX_W'(r_prod >>> grhh_pkg::NC_FRAC);
            end
        end
        // one row further, keep the point just left
        if (i_cmd.step) begin
            r_prev_x <= r_rx;
            r_prev_y <= r_ry;
            r_rx     <= r_rx + grhh_pkg::RX_W'(r_xo);
            if (r_down) begin
                r_ry <= r_ry - grhh_pkg::RY_W'(grhh_pkg::CELL_Q8);
            end else begin
                r_ry <= r_ry + grhh_pkg::RY_W'(grhh_pkg::CELL_Q8);
            end
        end
        // wall found behind the previous line
        if (i_cmd.back) begin
            r_rx <= r_prev_x;
            r_ry <= r_prev_y;
        end
        if (i_cmd.load_out) begin
            o_hit_x <= sat_out(r_rx);
            o_hit_y <= sat_out(ry_ext);
        end
    end

endmodule

>>> hdl/grid_ray_horizontal_hit_top.sv
// Horizontal grid-line ray caster over a wall map of 16-unit cells. Each input
// word is either a map write (tuser low), taken while idle, or a ray cast
// (tuser high) that yields one output word with the first horizontal-line hit
// in signed Q15.8. A cast runs its setup (accept with cotangent lookup, offset
// multiply, first crossing), then one row step per cycle, each step's wall
// check coming after its map read (the wall map has a single registered read
// port), and then loads the output register; an axis angle skips the walk.
// The next word is taken once the block is back in idle. The output register
// lets a new word be accepted while a result waits; a cast that finishes while
// that result is still not taken holds in its last cycle until it is. The wall
// map is not cleared by reset: cells must be written before a ray can reach
// them. The -cot table is a constant built at elaboration.
// Depends on grhh_pkg, grhh_ctrl and grhh_dpath.
module grid_ray_horizontal_hit_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [5:0] cell_col, [11:6] cell_row, [12] cell_wall, [30:13] player_x,
    // [48:31] player_y, [60:49] view_angle, [72:61] ray_offset, [79:73] zero
    input  logic [79:0] s_axis_tdata,
    // [0] cmd
    input  logic        s_axis_tuser,
    // output stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [23:0] hit_x, [47:24] hit_y
    output logic [47:0] m_axis_tdata,
    // configuration writes
    input  logic        i_cfg_we,
    input  logic [grhh_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [grhh_pkg::CFG_W-1:0]     i_cfg_data
);

    grhh_pkg::t_cmd cmd;
    grhh_pkg::t_sts sts;

    logic [grhh_pkg::OUT_W-1:0] hit_x;
    logic [grhh_pkg::OUT_W-1:0] hit_y;

    // controller
    grhh_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_in_kind   (s_axis_tuser),
        .o_in_ready  (s_axis_tready),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // datapath, fields unpacked from the input word
    grhh_dpath u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_cell_col   (s_axis_tdata[5:0]),
        .i_cell_row   (s_axis_tdata[11:6]),
        .i_cell_wall  (s_axis_tdata[12]),
        .i_player_x   (s_axis_tdata[30:13]),
        .i_player_y   (s_axis_tdata[48:31]),
        .i_view_angle (s_axis_tdata[60:49]),
        .i_ray_offset (s_axis_tdata[72:61]),
        .o_hit_x      (hit_x),
        .o_hit_y      (hit_y)
    );

    // pack the output word
    assign m_axis_tdata = {hit_y, hit_x};

endmodule

>>> hdl/grhh_checker.sv
// port-level checker for the ray caster, bound to the top level
// depends on grid_ray_horizontal_hit_top_defines.svh for the assertion macros
`include "grid_ray_horizontal_hit_top_defines.svh"

module grhh_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [47:0] m_axis_tdata
);

    logic cast_acc;
    logic write_acc;

    assign cast_acc  = s_axis_tvalid && s_axis_tready && s_axis_tuser;
    assign write_acc = s_axis_tvalid && s_axis_tready && !s_axis_tuser;

    // a stalled output word holds
    `GRHH_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "output word changed while stalled")
    // a cast occupies the block for its setup
    `GRHH_ASSERT_NEXT(a_cast_busy, cast_acc, !s_axis_tready, "word accepted during cast setup")
    `GRHH_ASSERT_DLY(a_cast_setup, cast_acc, 3, !s_axis_tready, "cast finished before setup and first check")
    // a map write leaves the block ready
    `GRHH_ASSERT_NEXT(a_write_ready, write_acc, s_axis_tready, "map write stalled the input")

endmodule

bind grid_ray_horizontal_hit_top grhh_checker u_grhh_checker (.*);
